// File: hw/rtl/ssq_pkg.sv
// Package for the stepper sweep sequencer: field widths, register indexes,
// reset values and segment codes. It depends on nothing else.
package ssq_pkg;

  // Field and state widths.
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STEPS_W  = 8;
  localparam int unsigned PULSE_W  = 8;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned SEG_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOW_PERIOD = 3'd0,
    REG_FAST_PERIOD = 3'd1,
    REG_SWEEP_STEPS = 3'd2,
    REG_SPIN_STEPS  = 3'd3,
    REG_PULSE_ODD   = 3'd4,
    REG_PULSE_EVEN  = 3'd5
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [PERIOD_W-1:0] RST_SLOW_PERIOD = 16'd1000;
  localparam logic [PERIOD_W-1:0] RST_FAST_PERIOD = 16'd500;
  localparam logic [STEPS_W-1:0]  RST_SWEEP_STEPS = 8'd16;
  localparam logic [STEPS_W-1:0]  RST_SPIN_STEPS  = 8'd48;
  localparam logic [PULSE_W-1:0]  RST_PULSE_ODD   = 8'd120;
  localparam logic [PULSE_W-1:0]  RST_PULSE_EVEN  = 8'd80;

  // Segment codes: sweeps run from the first to the last, then the spin.
  localparam logic [SEG_W-1:0] SEG_FIRST   = 3'd0;
  localparam logic [SEG_W-1:0] SEG_SPIN    = 3'd6;
  localparam logic [SEG_W-1:0] SEG_INVALID = 3'd7;

endpackage

// File: hw/rtl/ssq_ifs.sv
// Valid/ready channel interfaces for the stepper sweep sequencer.
// Depends on ssq_pkg for the field widths.
interface ssq_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface ssq_out_if import ssq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             coil_a_pos;
  logic             coil_a_neg;
  logic             coil_b_pos;
  logic             coil_b_neg;
  logic             servo_out;
  logic [SEG_W-1:0] segment_now;

  modport source (output valid, output coil_a_pos, output coil_a_neg, output coil_b_pos,
                  output coil_b_neg, output servo_out, output segment_now, input ready);
  modport sink   (input valid, input coil_a_pos, input coil_a_neg, input coil_b_pos,
                  input coil_b_neg, input servo_out, input segment_now, output ready);
endinterface

// File: hw/rtl/stepper_sweep_sequencer.sv
// Top level of the stepper sweep sequencer: configuration registers, sequencer
// state and the result register. Depends on ssq_pkg and the channel interfaces.
//
// One transaction on the input channel is one sample tick and yields exactly one
// result in the next cycle, held in the output register until taken. A new tick is
// accepted every cycle while the output register is empty or being emptied, so the
// sustained rate is one item per clock; the single update path from the state
// registers through the period compare to the result register sets that figure.
// The coils and segment_now reflect the phase and segment held before the tick;
// servo_out reflects the pulse counter after this tick's count-down. A tick of 0
// leaves all state alone and shows the held state. Configuration writes take effect
// at the next edge and should be made only while the block is idle.
module stepper_sweep_sequencer import ssq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ssq_in_if.sink                in_ch,
  ssq_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [PERIOD_W-1:0] slow_period_r;
  logic [PERIOD_W-1:0] fast_period_r;
  logic [STEPS_W-1:0]  sweep_steps_r;
  logic [STEPS_W-1:0]  spin_steps_r;
  logic [PULSE_W-1:0]  pulse_odd_r;
  logic [PULSE_W-1:0]  pulse_even_r;

  // Sequencer state.
  logic [PHASE_W-1:0]  phase_r,      phase_nxt;
  logic [PERIOD_W-1:0] tick_count_r, tick_count_nxt;
  logic [SEG_W-1:0]    segment_r,    segment_nxt;
  logic [STEPS_W-1:0]  seg_steps_r,  seg_steps_nxt;
  logic [PULSE_W-1:0]  pulse_left_r, pulse_left_nxt;
  logic                fast_mode_r,  fast_mode_nxt;

  // Output register.
  logic                out_valid_r;
  logic                coil_a_r, coil_b_r, servo_r;
  logic [SEG_W-1:0]    seg_out_r;

  logic                in_acc;
  logic                spinning;
  logic                pulse_live;
  logic [PULSE_W-1:0]  pulse_dec;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] count_inc;
  logic                do_step;
  logic [STEPS_W-1:0]  steps_inc;
  logic [SEG_W-1:0]    seg_inc;
  logic                servo_val;

  // Handshake: the output register frees itself when the sink takes its content.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_period_r <= RST_SLOW_PERIOD;
      fast_period_r <= RST_FAST_PERIOD;
      sweep_steps_r <= RST_SWEEP_STEPS;
      spin_steps_r  <= RST_SPIN_STEPS;
      pulse_odd_r   <= RST_PULSE_ODD;
      pulse_even_r  <= RST_PULSE_EVEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOW_PERIOD: slow_period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_FAST_PERIOD: fast_period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_SWEEP_STEPS: sweep_steps_r <= cfg_wdata[STEPS_W-1:0];
        REG_SPIN_STEPS:  spin_steps_r  <= cfg_wdata[STEPS_W-1:0];
        REG_PULSE_ODD:   pulse_odd_r   <= cfg_wdata[PULSE_W-1:0];
        REG_PULSE_EVEN:  pulse_even_r  <= cfg_wdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pulse count-down, which stops at zero, and the servo level it gives.
  assign pulse_live = (pulse_left_r != '0);
  assign pulse_dec  = pulse_left_r - PULSE_W'(pulse_live);
  assign servo_val  = in_ch.tick ? (pulse_dec != '0) : pulse_live;

  // Period counter and step decision. The unused top code counts as spin.
  assign spinning  = segment_r[2] && segment_r[1];
  assign period    = fast_mode_r ? fast_period_r : slow_period_r;
  assign count_inc = tick_count_r + PERIOD_W'(1);
  assign do_step   = (count_inc >= period);
  assign steps_inc = seg_steps_r + STEPS_W'(1);
  assign seg_inc   = segment_r + SEG_W'(1);

  // Next state for an accepted tick.
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    segment_nxt    = segment_r;
    seg_steps_nxt  = seg_steps_r;
    pulse_left_nxt = pulse_left_r;
    fast_mode_nxt  = fast_mode_r;
    if (in_ch.tick) begin
      pulse_left_nxt = pulse_dec;
      tick_count_nxt = do_step ? '0 : count_inc;
      if (do_step) begin
        // Forward on even segments and in the spin, backward on odd sweeps.
        if (spinning || !segment_r[0]) begin
          phase_nxt = phase_r + PHASE_W'(1);
        end else begin
          phase_nxt = phase_r - PHASE_W'(1);
        end
        seg_steps_nxt = steps_inc;
        if (spinning) begin
          if (steps_inc >= spin_steps_r) begin
            seg_steps_nxt = '0;
            segment_nxt   = SEG_FIRST;
            fast_mode_nxt = 1'b0;
          end
        end else if (steps_inc >= sweep_steps_r) begin
          seg_steps_nxt  = '0;
          segment_nxt    = seg_inc;
          pulse_left_nxt = seg_inc[0] ? pulse_odd_r : pulse_even_r;
          if (seg_inc == SEG_SPIN) begin
            fast_mode_nxt = 1'b1;
          end
        end
      end
    end
  end

  // State registers advance only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      tick_count_r <= '0;
      segment_r    <= SEG_FIRST;
      seg_steps_r  <= '0;
      pulse_left_r <= '0;
      fast_mode_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      segment_r    <= segment_nxt;
      seg_steps_r  <= seg_steps_nxt;
      pulse_left_r <= pulse_left_nxt;
      fast_mode_r  <= fast_mode_nxt;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, taken from the state held before the update.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      coil_a_r  <= (phase_r == 2'd1) || (phase_r == 2'd2);
      coil_b_r  <= (phase_r == 2'd0) || (phase_r == 2'd1);
      servo_r   <= servo_val;
      seg_out_r <= segment_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.coil_a_pos  = coil_a_r;
  assign out_ch.coil_a_neg  = !coil_a_r;
  assign out_ch.coil_b_pos  = coil_b_r;
  assign out_ch.coil_b_neg  = !coil_b_r;
  assign out_ch.servo_out   = servo_r;
  assign out_ch.segment_now = seg_out_r;

`ifndef SYNTHESIS
  // The unused segment code is never reached.
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    segment_r != SEG_INVALID)
    else $error("segment register holds the unused code");

  // The fast period is in use exactly during the spin.
  a_fast_spin: assert property (@(posedge clk) disable iff (!rst_n)
    fast_mode_r == (segment_r == SEG_SPIN))
    else $error("fast mode out of step with the spin segment");

  // The phase moves by at most one full step per transaction.
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (phase_r == $past(phase_r) || phase_r == $past(phase_r) + 2'd1 ||
                phase_r == $past(phase_r) - 2'd1))
    else $error("phase jumped by more than one step");

  // A hold tick leaves the sequencer state untouched.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.tick) |=> ($stable(phase_r) && $stable(tick_count_r) &&
                                 $stable(segment_r) && $stable(pulse_left_r)))
    else $error("state changed on a hold tick");

  // Every accepted transaction leaves a result waiting.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction produced no result");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for stepper_sweep_sequencer: drives tick transactions, predicts the
// coil, servo and segment outputs and compares each result. Depends on ssq_pkg and ssq_ifs.
module tb;
  import ssq_pkg::*;

  // Register indexes that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             a_pos;
    logic             a_neg;
    logic             b_pos;
    logic             b_neg;
    logic             servo;
    logic [SEG_W-1:0] segment;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ssq_in_if  in_ch ();
  ssq_out_if out_ch ();

  stepper_sweep_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the configuration registers.
  logic [PERIOD_W-1:0] slow_period = RST_SLOW_PERIOD;
  logic [PERIOD_W-1:0] fast_period = RST_FAST_PERIOD;
  logic [STEPS_W-1:0]  sweep_steps = RST_SWEEP_STEPS;
  logic [STEPS_W-1:0]  spin_steps  = RST_SPIN_STEPS;
  logic [PULSE_W-1:0]  pulse_odd   = RST_PULSE_ODD;
  logic [PULSE_W-1:0]  pulse_even  = RST_PULSE_EVEN;

  // Shadow copy of the sequencer state.
  logic [PHASE_W-1:0]  phase = '0;
  logic [PERIOD_W-1:0] tick_count = '0;
  logic [SEG_W-1:0]    segment = SEG_FIRST;
  logic [STEPS_W-1:0]  segment_steps = '0;
  logic [PULSE_W-1:0]  pulse_left = '0;
  logic                fast_mode = 1'b0;

  logic   pending_ticks[$];
  drive_t expected_drive[$];
  drive_t want;
  int     error_count = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;

  always #1 clk = ~clk;

  // Works out the outputs for one tick and advances the shadow state.
  function automatic drive_t advance_sequencer(input logic tick);
    drive_t              r;
    logic [PERIOD_W-1:0] period;
    logic                spinning;
    r.a_pos   = (phase == 2'd1) || (phase == 2'd2);
    r.a_neg   = !r.a_pos;
    r.b_pos   = (phase == 2'd0) || (phase == 2'd1);
    r.b_neg   = !r.b_pos;
    r.segment = segment;
    if (tick) begin
      if (pulse_left != 0) pulse_left = pulse_left - PULSE_W'(1);
      r.servo    = (pulse_left != 0);
      period     = fast_mode ? fast_period : slow_period;
      tick_count = tick_count + PERIOD_W'(1);
      if (tick_count >= period) begin
        spinning = (segment >= SEG_SPIN);
        // Even sweeps and the spin turn forward, odd sweeps turn back.
        if (spinning || !segment[0]) begin
          phase = phase + PHASE_W'(1);
        end else begin
          phase = phase - PHASE_W'(1);
        end
        segment_steps = segment_steps + STEPS_W'(1);
        if (spinning) begin
          if (segment_steps >= spin_steps) begin
            segment_steps = '0;
            segment       = SEG_FIRST;
            fast_mode     = 1'b0;
          end
        end else if (segment_steps >= sweep_steps) begin
          segment_steps = '0;
          segment       = segment + SEG_W'(1);
          pulse_left    = segment[0] ? pulse_odd : pulse_even;
          if (segment == SEG_SPIN) fast_mode = 1'b1;
        end
        tick_count = '0;
      end
    end else begin
      r.servo = (pulse_left != 0);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [SEG_W-1:0] exp_v,
                             input logic [SEG_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t tb: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Driver: presents queued ticks and records the prediction of each accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.tick  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_drive.push_back(advance_sequencer(in_ch.tick));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.tick  <= pending_ticks.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
          in_ch.tick  <= 1'($urandom_range(1, 0));
        end
      end
    end
  end

  // Monitor: takes results and compares them with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_drive.size() == 0) begin
          $display("%0t tb: result with nothing expected, expected none, actual segment %0d",
                   $time, out_ch.segment_now);
          error_count++;
        end else begin
          want = expected_drive.pop_front();
          check_field("coil_a_pos", SEG_W'(want.a_pos), SEG_W'(out_ch.coil_a_pos));
          check_field("coil_a_neg", SEG_W'(want.a_neg), SEG_W'(out_ch.coil_a_neg));
          check_field("coil_b_pos", SEG_W'(want.b_pos), SEG_W'(out_ch.coil_b_pos));
          check_field("coil_b_neg", SEG_W'(want.b_neg), SEG_W'(out_ch.coil_b_neg));
          check_field("servo_out", SEG_W'(want.servo), SEG_W'(out_ch.servo_out));
          check_field("segment_now", want.segment, out_ch.segment_now);
        end
      end
      out_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  // Register write at the next edge; the enable is lowered by end_writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SLOW_PERIOD: slow_period = val;
      REG_FAST_PERIOD: fast_period = val;
      REG_SWEEP_STEPS: sweep_steps = val[STEPS_W-1:0];
      REG_SPIN_STEPS:  spin_steps  = val[STEPS_W-1:0];
      REG_PULSE_ODD:   pulse_odd   = val[PULSE_W-1:0];
      REG_PULSE_EVEN:  pulse_even  = val[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Holds the sender back until every queued tick has been taken and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_ch.valid || expected_drive.size() != 0);
  endtask

  task automatic queue_pattern(input logic [15:0] bits, input int n);
    for (int i = 0; i < n; i++) pending_ticks.push_back(bits[i]);
  endtask

  // Mostly short periods so that the segments turn over; now and then a long one.
  function automatic logic [CFG_DATA_W-1:0] pick_period();
    if ($urandom_range(7, 0) == 0) return CFG_DATA_W'($urandom_range(65535, 0));
    return CFG_DATA_W'($urandom_range(4, 0));
  endfunction

  // Step counts: mostly small, now and then 255, with random upper bits the block must drop.
  function automatic logic [CFG_DATA_W-1:0] pick_steps();
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    v[7:0] = ($urandom_range(9, 0) == 0) ? 8'd255 : 8'($urandom_range(3, 0));
    return v;
  endfunction

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.tick   = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: hold ticks and plain ticks.
    queue_pattern(16'b11010, 5);
    wait_drained();

    // Every tick a step and every step a new segment, through the spin and back.
    write_reg(REG_SLOW_PERIOD, 16'd1);
    write_reg(REG_FAST_PERIOD, 16'd1);
    write_reg(REG_SWEEP_STEPS, 16'd1);
    write_reg(REG_SPIN_STEPS, 16'd1);
    write_reg(REG_PULSE_ODD, 16'd255);
    write_reg(REG_PULSE_EVEN, 16'd0);
    end_writes();
    queue_pattern(16'b111110111, 9);
    wait_drained();

    // Zero periods and zero step counts.
    write_reg(REG_SLOW_PERIOD, 16'd0);
    write_reg(REG_FAST_PERIOD, 16'd0);
    write_reg(REG_SWEEP_STEPS, 16'd0);
    write_reg(REG_SPIN_STEPS, 16'd0);
    write_reg(REG_PULSE_ODD, 16'd0);
    write_reg(REG_PULSE_EVEN, 16'd255);
    end_writes();
    queue_pattern(16'b1110111, 7);
    wait_drained();

    // Spare indexes are ignored and upper data bits are dropped; then a period is
    // lowered beneath a count that is already running.
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    write_reg(REG_SWEEP_STEPS, 16'hFF03);
    write_reg(REG_SLOW_PERIOD, 16'd50);
    end_writes();
    queue_pattern(16'b111, 3);
    wait_drained();
    write_reg(REG_SLOW_PERIOD, 16'd2);
    end_writes();
    queue_pattern(16'b11, 2);
    wait_drained();

    // Random rounds under each idling pattern; the first round of the first two
    // patterns uses an extreme setting.
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 87 : 0;
      snk_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 34 : 0;
      for (int round = 0; round < 3; round++) begin
        if (round == 0 && mode == 0) begin
          write_reg(REG_SLOW_PERIOD, 16'hFFFF);
          write_reg(REG_FAST_PERIOD, 16'hFFFF);
          write_reg(REG_SWEEP_STEPS, 16'h00FF);
          write_reg(REG_SPIN_STEPS, 16'h00FF);
          write_reg(REG_PULSE_ODD, 16'h00FF);
          write_reg(REG_PULSE_EVEN, 16'h00FF);
        end else if (round == 0 && mode == 1) begin
          write_reg(REG_SLOW_PERIOD, 16'd1);
          write_reg(REG_FAST_PERIOD, 16'd1);
          write_reg(REG_SWEEP_STEPS, 16'd1);
          write_reg(REG_SPIN_STEPS, 16'd1);
          write_reg(REG_PULSE_ODD, 16'd1);
          write_reg(REG_PULSE_EVEN, 16'd2);
        end else begin
          write_reg(REG_SLOW_PERIOD, pick_period());
          write_reg(REG_FAST_PERIOD, pick_period());
          write_reg(REG_SWEEP_STEPS, pick_steps());
          write_reg(REG_SPIN_STEPS, pick_steps());
          write_reg(REG_PULSE_ODD, CFG_DATA_W'($urandom));
          write_reg(REG_PULSE_EVEN, CFG_DATA_W'($urandom));
        end
        end_writes();
        for (int i = 0; i < 50; i++) pending_ticks.push_back($urandom_range(99, 0) < 85);
        wait_drained();
      end
    end

    repeat (8) @(posedge clk);
    if (expected_drive.size() != 0) begin
      $display("%0t tb: results missing, expected %0d more, actual 0", $time,
               expected_drive.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
